/* rtl/core/dmh_pkg.sv */
// shared types, sizes and codes for the deadline min-heap timer queue
// no dependencies; used by every module of the block but the ram
`timescale 1ns / 1ps

package dmh_pkg;

    localparam int CAPACITY = 32;
    localparam int TAG_BITS = 16;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KID_W = IDX_W + 2;
    localparam int DL_W  = 64;
    localparam int ENT_W = DL_W + TAG_BITS;

    localparam logic OP_ARM   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [1:0] ST_ARMED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_FIRED = 2'd2;
    localparam logic [1:0] ST_IDLE  = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [63:0] deadline;
        logic [15:0] timer_tag;
        logic [63:0] current_time;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] fired_tag;
        logic [63:0] fired_deadline;
        logic [5:0]  pending_count;
    } result_t;

    typedef struct packed {
        logic [DL_W-1:0]     deadline;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic rsp_full;
        logic rsp_idle;
        logic rd_parent;
        logic arm_move;
        logic arm_place;
        logic rd_root;
        logic fire;
        logic fire_last;
        logic rd_kids;
        logic dn_move;
        logic dn_place;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic op;
        logic full;
        logic empty;
        logic at_root;
        logic move_up;
        logic due;
        logic last_one;
        logic dn_stop;
    } sts_t;

endpackage

/* rtl/core/dmh_ram.sv */
// generic simple dual-port ram: one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps

module dmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* rtl/core/dmh_ctrl.sv */
// controller state machine for the timer queue: sequences arm, check and sifts
// depends on dmh_pkg
`timescale 1ns / 1ps

module dmh_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  dmh_pkg::sts_t sts,
    output dmh_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ARM_RD  = 3'd1;
    localparam logic [2:0] S_ARM_CMP = 3'd2;
    localparam logic [2:0] S_CHK_RD  = 3'd3;
    localparam logic [2:0] S_CHK_CMP = 3'd4;
    localparam logic [2:0] S_DN_RD   = 3'd5;
    localparam logic [2:0] S_DN_CMP  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (sts.op == dmh_pkg::OP_ARM)
                    begin
                        if (sts.full)
                        begin
                            cmd.rsp_full = 1'b1;
                        end
                        else
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_ARM_RD;
                        end
                    end
                    else
                    begin
                        if (sts.empty)
                        begin
                            cmd.rsp_idle = 1'b1;
                        end
                        else
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_CHK_RD;
                        end
                    end
                end
            end
            S_ARM_RD:
            begin
                if (sts.at_root)
                begin
                    cmd.arm_place = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_ARM_CMP;
                end
            end
            S_ARM_CMP:
            begin
                if (sts.move_up)
                begin
                    cmd.arm_move = 1'b1;
                    state_next   = S_ARM_RD;
                end
                else
                begin
                    cmd.arm_place = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_CHK_RD:
            begin
                cmd.rd_root = 1'b1;
                state_next  = S_CHK_CMP;
            end
            S_CHK_CMP:
            begin
                if (!sts.due)
                begin
                    cmd.rsp_idle = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (sts.last_one)
                begin
                    cmd.fire_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.fire   = 1'b1;
                    state_next = S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                cmd.rd_kids = 1'b1;
                state_next  = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (sts.dn_stop)
                begin
                    cmd.dn_place = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a transfer is only taken from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE) && start)
        else $error("load outside idle");

    // an arm compare is always entered from an arm read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ARM_CMP) |-> $past(state_reg) == S_ARM_RD)
        else $error("arm compare without read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DN_RD) |-> ($past(state_reg) == S_CHK_CMP)
                                   || ($past(state_reg) == S_DN_CMP))
        else $error("sift-down entered from wrong state");

endmodule

/* rtl/core/dmh_dpath.sv */
// datapath of the timer queue: heap ram, count, sift position and result register
// depends on dmh_pkg and dmh_ram
`timescale 1ns / 1ps

module dmh_dpath (
    input  logic            clk,
    input  logic            rst_n,
    input  dmh_pkg::item_t  item,
    input  dmh_pkg::cmd_t   cmd,
    output dmh_pkg::sts_t   sts,
    output logic            done,
    output dmh_pkg::result_t result
);

    logic [dmh_pkg::CNT_W-1:0] count_reg;
    logic [dmh_pkg::CNT_W-1:0] count_next;
    logic                      done_reg;
    logic                      done_next;
    dmh_pkg::result_t          result_reg;
    dmh_pkg::result_t          result_next;

    logic [dmh_pkg::IDX_W-1:0] pos_reg;
    dmh_pkg::entry_t           new_reg;
    dmh_pkg::entry_t           mov_reg;
    dmh_pkg::entry_t           fired_reg;
    logic [dmh_pkg::DL_W-1:0]  now_reg;

    dmh_pkg::entry_t           rd_a;
    dmh_pkg::entry_t           rd_b;
    logic                      we;
    logic [dmh_pkg::IDX_W-1:0] waddr;
    dmh_pkg::entry_t           wdata;
    logic [dmh_pkg::IDX_W-1:0] raddr_a;
    logic [dmh_pkg::IDX_W-1:0] raddr_b;

    logic [dmh_pkg::IDX_W-1:0] parent;
    logic [dmh_pkg::KID_W-1:0] kid_l;
    logic [dmh_pkg::KID_W-1:0] kid_r;
    logic [dmh_pkg::KID_W-1:0] count_wide;
    logic                      l_ok;
    logic                      r_ok;
    logic                      lt_am;
    logic                      lt_bm;
    logic                      lt_ba;
    logic                      take_l;
    logic                      take_r;
    logic [dmh_pkg::KID_W-1:0] kid;
    dmh_pkg::entry_t           kid_ent;

    dmh_ram #(
        .WIDTH (dmh_pkg::ENT_W),
        .DEPTH (dmh_pkg::CAPACITY)
    ) u_heap (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // heap index arithmetic
    assign parent     = dmh_pkg::IDX_W'((pos_reg - 1'b1) >> 1);
    assign kid_l      = {1'b0, pos_reg, 1'b1};
    assign kid_r      = kid_l + 1'b1;
    assign count_wide = dmh_pkg::KID_W'(count_reg);
    assign l_ok       = kid_l < count_wide;
    assign r_ok       = kid_r < count_wide;

    // three compares side by side, left child wins ties
    assign lt_am  = rd_a.deadline < mov_reg.deadline;
    assign lt_bm  = rd_b.deadline < mov_reg.deadline;
    assign lt_ba  = rd_b.deadline < rd_a.deadline;
    assign take_l = l_ok && lt_am;
    assign take_r = r_ok && (take_l ? lt_ba : lt_bm);
    assign kid     = take_r ? kid_r : kid_l;
    assign kid_ent = take_r ? rd_b : rd_a;

    assign sts.op       = item.operation;
    assign sts.full     = (count_reg == dmh_pkg::CNT_W'(dmh_pkg::CAPACITY));
    assign sts.empty    = (count_reg == '0);
    assign sts.at_root  = (pos_reg == '0);
    assign sts.move_up  = new_reg.deadline < rd_a.deadline;
    assign sts.due      = rd_a.deadline <= now_reg;
    assign sts.last_one = (count_reg == dmh_pkg::CNT_W'(1));
    assign sts.dn_stop  = !take_l && !take_r;

    always_comb
    begin
        if (cmd.rd_root)
        begin
            raddr_a = '0;
            raddr_b = dmh_pkg::IDX_W'(count_reg - 1'b1);
        end
        else if (cmd.rd_parent)
        begin
            raddr_a = parent;
            raddr_b = parent;
        end
        else
        begin
            raddr_a = dmh_pkg::IDX_W'(kid_l);
            raddr_b = dmh_pkg::IDX_W'(kid_r);
        end
    end

    assign we    = cmd.arm_place | cmd.arm_move | cmd.dn_place | cmd.dn_move;
    assign waddr = pos_reg;

    always_comb
    begin
        if (cmd.arm_place)
        begin
            wdata = new_reg;
        end
        else if (cmd.arm_move)
        begin
            wdata = rd_a;
        end
        else if (cmd.dn_place)
        begin
            wdata = mov_reg;
        end
        else
        begin
            wdata = kid_ent;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.arm_place)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.fire || cmd.fire_last)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        done_next                 = cmd.rsp_full | cmd.rsp_idle | cmd.arm_place
                                  | cmd.fire_last | cmd.dn_place;
        result_next               = '0;
        result_next.pending_count = 6'(count_next);
        if (cmd.rsp_full)
        begin
            result_next.status = dmh_pkg::ST_FULL;
        end
        else if (cmd.rsp_idle)
        begin
            result_next.status = dmh_pkg::ST_IDLE;
        end
        else if (cmd.arm_place)
        begin
            result_next.status = dmh_pkg::ST_ARMED;
        end
        else if (cmd.fire_last)
        begin
            result_next.status         = dmh_pkg::ST_FIRED;
            result_next.fired_tag      = 16'(rd_a.tag);
            result_next.fired_deadline = rd_a.deadline;
        end
        else
        begin
            result_next.status         = dmh_pkg::ST_FIRED;
            result_next.fired_tag      = 16'(fired_reg.tag);
            result_next.fired_deadline = fired_reg.deadline;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            result_reg <= result_next;
        end
        if (cmd.load)
        begin
            new_reg.deadline <= item.deadline;
            new_reg.tag      <= dmh_pkg::TAG_BITS'(item.timer_tag);
            now_reg          <= item.current_time;
            pos_reg          <= dmh_pkg::IDX_W'(count_reg);
        end
        else if (cmd.arm_move)
        begin
            pos_reg <= parent;
        end
        else if (cmd.fire)
        begin
            fired_reg <= rd_a;
            mov_reg   <= rd_b;
            pos_reg   <= '0;
        end
        else if (cmd.dn_move)
        begin
            pos_reg <= dmh_pkg::IDX_W'(kid);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // an accepted arm adds exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (result_reg.status == dmh_pkg::ST_ARMED)
        |-> count_reg == $past(count_reg) + 1'b1)
        else $error("arm did not grow the heap by one");

    // a rejection only when full, and the heap is left alone
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (result_reg.status == dmh_pkg::ST_FULL)
        |-> (count_reg == dmh_pkg::CNT_W'(dmh_pkg::CAPACITY)) && $stable(count_reg))
        else $error("rejection with room left");

    // ram reads and writes are never issued in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> !(cmd.rd_root || cmd.rd_parent || cmd.rd_kids))
        else $error("read and write collide");

endmodule

/* rtl/core/deadline_min_heap_timer_queue.sv */
// timer queue top level: arm or check items in, one result per item out
// arm: rejected if full; else climbs level by level, then is placed
// check: idle if empty or the root is not due; else the root fires, then sifts if any remain
// busy stays high until a loaded item's strobe; one item at a time, every level a ram read
// the receiver cannot stall; done is a one-cycle strobe with result held that cycle
// reset (rst_n low, asynchronous) empties the heap; ram contents are not cleared
`timescale 1ns / 1ps

module deadline_min_heap_timer_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dmh_pkg::item_t   item,
    output logic             done,
    output dmh_pkg::result_t result
);

    dmh_pkg::cmd_t cmd;
    dmh_pkg::sts_t sts;

    dmh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    dmh_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .done   (done),
        .result (result)
    );

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the deadline min-heap timer queue
// depends on dmh_pkg and deadline_min_heap_timer_queue; predicts every result in-line
`timescale 1ns / 1ps

module tb_top;

    import dmh_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_PRINTS   = 60;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   stim = '0;
    logic    busy;
    logic    done;
    result_t result;

    // shadow copy of the heap, updated at each accepted transfer
    logic [DL_W-1:0]     shadow_dl [CAPACITY];
    logic [TAG_BITS-1:0] shadow_tag [CAPACITY];
    int                  shadow_count = 0;

    item_t   item_backlog [$];
    result_t predicted_results [$];
    int      offered_count = 0;
    int      accepted_count = 0;
    int      total_items = 0;
    int      error_count = 0;
    int      gap_left = 0;
    int      calm_left = 0;

    deadline_min_heap_timer_queue uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (stim),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    task automatic flag_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    function automatic void swap_slots(input int a, input int b);
        logic [DL_W-1:0]     dl;
        logic [TAG_BITS-1:0] tg;
        dl = shadow_dl[a];
        tg = shadow_tag[a];
        shadow_dl[a] = shadow_dl[b];
        shadow_tag[a] = shadow_tag[b];
        shadow_dl[b] = dl;
        shadow_tag[b] = tg;
    endfunction

    function automatic result_t timer_queue_step(input item_t it);
        result_t r;
        int      pos;
        int      up;
        int      lft;
        int      rgt;
        int      best;
        r = '0;
        if (it.operation == OP_ARM) begin
            if (shadow_count >= CAPACITY) begin
                r.status = ST_FULL;
            end
            else begin
                pos = shadow_count;
                shadow_dl[pos] = it.deadline;
                shadow_tag[pos] = it.timer_tag[TAG_BITS-1:0];
                // equal deadlines stop the climb
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (shadow_dl[pos] >= shadow_dl[up])
                        break;
                    swap_slots(pos, up);
                    pos = up;
                end
                shadow_count++;
                r.status = ST_ARMED;
            end
        end
        else if (shadow_count == 0 || shadow_dl[0] > it.current_time) begin
            r.status = ST_IDLE;
        end
        else begin
            r.status = ST_FIRED;
            r.fired_deadline = shadow_dl[0];
            r.fired_tag = 16'(shadow_tag[0]);
            shadow_count--;
            if (shadow_count > 0) begin
                shadow_dl[0] = shadow_dl[shadow_count];
                shadow_tag[0] = shadow_tag[shadow_count];
                pos = 0;
                // left child wins ties
                while (1) begin
                    lft = 2 * pos + 1;
                    rgt = 2 * pos + 2;
                    best = pos;
                    if (lft < shadow_count && shadow_dl[lft] < shadow_dl[best])
                        best = lft;
                    if (rgt < shadow_count && shadow_dl[rgt] < shadow_dl[best])
                        best = rgt;
                    if (best == pos)
                        break;
                    swap_slots(pos, best);
                    pos = best;
                end
            end
        end
        r.pending_count = 6'(shadow_count);
        return r;
    endfunction

    // unused fields carry noise so that the block is seen to ignore them
    function automatic item_t arm_item(input logic [63:0] dl, input logic [15:0] tg);
        item_t it;
        it.operation = OP_ARM;
        it.deadline = dl;
        it.timer_tag = tg;
        it.current_time = {$urandom, $urandom};
        return it;
    endfunction

    function automatic item_t check_item(input logic [63:0] now);
        item_t it;
        it.operation = OP_CHECK;
        it.deadline = {$urandom, $urandom};
        it.timer_tag = 16'($urandom);
        it.current_time = now;
        return it;
    endfunction

    // driver: one item in flight on the start line, random gaps between transfers
    always @(negedge clk) begin
        int next_gap;
        if (rst_n) begin
            if (start && accepted_count == offered_count) begin
                if (calm_left > 0) begin
                    calm_left--;
                    next_gap = 0;
                end
                else if ($urandom_range(0, 15) == 0) begin
                    calm_left = $urandom_range(10, 40);
                    next_gap = 0;
                end
                else begin
                    next_gap = $urandom_range(0, 15);
                end
                if (next_gap == 0 && item_backlog.size() > 0) begin
                    stim <= item_backlog.pop_front();
                    offered_count++;
                end
                else begin
                    start <= 1'b0;
                    gap_left <= (next_gap == 0) ? 0 : next_gap - 1;
                end
            end
            else if (!start) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end
                else if (item_backlog.size() > 0) begin
                    start <= 1'b1;
                    stim <= item_backlog.pop_front();
                    offered_count++;
                end
            end
        end
    end

    // monitor: check the result strobe, then predict for a transfer at this edge
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (done) begin
                if (predicted_results.size() == 0) begin
                    flag_mismatch("result with nothing outstanding");
                end
                else begin
                    want = predicted_results.pop_front();
                    if (result.status !== want.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                result.status, want.status));
                    if (result.fired_tag !== want.fired_tag)
                        flag_mismatch($sformatf("fired_tag %h, want %h",
                                                result.fired_tag, want.fired_tag));
                    if (result.fired_deadline !== want.fired_deadline)
                        flag_mismatch($sformatf("fired_deadline %h, want %h",
                                                result.fired_deadline,
                                                want.fired_deadline));
                    if (result.pending_count !== want.pending_count)
                        flag_mismatch($sformatf("pending_count %0d, want %0d",
                                                result.pending_count,
                                                want.pending_count));
                end
            end
            if (start && !busy) begin
                predicted_results.push_back(timer_queue_step(stim));
                accepted_count++;
            end
        end
    end

    initial begin
        logic [63:0] base;
        logic [63:0] dl;
        logic [63:0] now;
        int          made;
        int          phase_left;
        int          arm_pct;
        int          pick;

        // empty heap, extremes, ties, not yet due, due on equality
        item_backlog.push_back(check_item('1));
        item_backlog.push_back(check_item('0));
        item_backlog.push_back(arm_item('1, 16'hFFFF));
        item_backlog.push_back(arm_item('0, 16'h0000));
        item_backlog.push_back(arm_item(64'd100, 16'h0001));
        item_backlog.push_back(arm_item(64'd100, 16'h0002));
        item_backlog.push_back(arm_item(64'd50, 16'h0003));
        item_backlog.push_back(arm_item(64'd100, 16'h0004));
        item_backlog.push_back(check_item(64'd49));
        item_backlog.push_back(check_item(64'd49));
        item_backlog.push_back(check_item(64'd50));
        repeat (3) item_backlog.push_back(check_item(64'd100));
        item_backlog.push_back(check_item(64'hFFFF_FFFF_FFFF_FFFE));
        item_backlog.push_back(check_item('1));
        item_backlog.push_back(check_item('1));
        // falling deadlines climb all the way to the root; the last arm meets a full heap
        for (int i = 0; i <= CAPACITY; i++)
            item_backlog.push_back(arm_item(64'd2000 - 64'(10 * i), 16'($urandom)));

        // phases lean towards filling, mixing or draining around a moving time base
        made = 0;
        while (made < RANDOM_ITEMS) begin
            phase_left = $urandom_range(20, 80);
            pick = $urandom_range(0, 2);
            arm_pct = (pick == 0) ? 85 : (pick == 1) ? 50 : 20;
            base = {$urandom, $urandom} >> $urandom_range(0, 63);
            while (phase_left > 0 && made < RANDOM_ITEMS) begin
                if ($urandom_range(0, 99) < arm_pct) begin
                    if ($urandom_range(0, 9) < 8)
                        dl = base + 64'($urandom_range(0, 255));
                    else
                        dl = {$urandom, $urandom};
                    item_backlog.push_back(arm_item(dl, 16'($urandom)));
                end
                else begin
                    pick = $urandom_range(0, 19);
                    if (pick < 12)
                        now = base + 64'($urandom_range(0, 300));
                    else if (pick < 15)
                        now = '1;
                    else if (pick < 17)
                        now = '0;
                    else
                        now = {$urandom, $urandom};
                    item_backlog.push_back(check_item(now));
                end
                base = base + 64'($urandom_range(0, 8));
                phase_left--;
                made++;
            end
        end
        total_items = item_backlog.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (accepted_count == total_items && predicted_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/dmh_pkg.sv
rtl/core/dmh_ram.sv
rtl/core/dmh_ctrl.sv
rtl/core/dmh_dpath.sv
rtl/core/deadline_min_heap_timer_queue.sv
tb/sv/tb_top.sv
